// ===== hw/rtl/pedestrian_ttc_speed_limit_defines.svh =====
// Assertion macros shared by the checker.
`ifndef PEDESTRIAN_TTC_SPEED_LIMIT_DEFINES_SVH
`define PEDESTRIAN_TTC_SPEED_LIMIT_DEFINES_SVH

// same-cycle implication
`define PTSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptsl checker: property failed");

// next-cycle implication
`define PTSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptsl checker: property failed");

`endif

// ===== hw/rtl/ptsl_pkg.sv =====
package ptsl_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int SQRT_STEPS        = 20;
    localparam int DIV_W             = 49;
    localparam int DIVISOR_W         = 25;
    localparam int CNT_W             = 6;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_ARC  = 3'd0,
        CFG_STOP_DIST = 3'd1,
        CFG_TTC_THR   = 3'd2,
        CFG_MAX_DECEL = 3'd3,
        CFG_FLOOR_VEL = 3'd4
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_VEC,
        OP_DMUL,
        OP_DIST,
        OP_ROT,
        OP_LMUL,
        OP_LD,
        OP_ADMUL,
        OP_VVMUL,
        OP_DISC,
        OP_SQRT,
        OP_TPREP,
        OP_DIV,
        OP_TUPD,
        OP_FMUL1,
        OP_FMUL2,
        OP_FPREP,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_VEC,
        ST_DMUL,
        ST_DIST,
        ST_ROT,
        ST_LMUL,
        ST_LD,
        ST_ADMUL,
        ST_VVMUL,
        ST_DISC,
        ST_SQRT,
        ST_TPREP,
        ST_TDIV,
        ST_TUPD,
        ST_EVAL,
        ST_FMUL1,
        ST_FMUL2,
        ST_FPREP,
        ST_FDIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic present;
        logic last;
        logic out_of_arc;
        logic stop_short;
        logic need_div;
        logic out_free;
    } dp_status_t;

    // arctan(2^-i) in Q3.13
    function automatic logic signed [19:0] atan_q13(input logic [CNT_W-1:0] i);
        logic signed [19:0] r;
        case (i)
            6'd0:    r = 20'sd6434;
            6'd1:    r = 20'sd3798;
            6'd2:    r = 20'sd2007;
            6'd3:    r = 20'sd1019;
            6'd4:    r = 20'sd511;
            6'd5:    r = 20'sd256;
            6'd6:    r = 20'sd128;
            6'd7:    r = 20'sd64;
            6'd8:    r = 20'sd32;
            6'd9:    r = 20'sd16;
            6'd10:   r = 20'sd8;
            6'd11:   r = 20'sd4;
            6'd12:   r = 20'sd2;
            6'd13:   r = 20'sd1;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/ptsl_ifs.sv =====
interface ptsl_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] speed;
    logic signed [31:0] veh_x;
    logic signed [31:0] veh_y;
    logic signed [15:0] heading;
    logic signed [31:0] ped_x;
    logic signed [31:0] ped_y;
    logic               ped_present;
    logic               last;

    modport source (output valid, speed, veh_x, veh_y, heading, ped_x, ped_y,
                    ped_present, last, input ready);
    modport sink (input valid, speed, veh_x, veh_y, heading, ped_x, ped_y,
                  ped_present, last, output ready);
endinterface

interface ptsl_out_if;
    logic        valid;
    logic        ready;
    logic        limited;
    logic [15:0] max_speed;
    logic [15:0] min_ttc;
    logic        ttc_finite;

    modport source (output valid, limited, max_speed, min_ttc, ttc_finite, input ready);
    modport sink (input valid, limited, max_speed, min_ttc, ttc_finite, output ready);
endinterface

interface ptsl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ptsl_ctrl.sv =====
module ptsl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output ptsl_pkg::dp_cmd_t    cmd,
    input  ptsl_pkg::dp_status_t status
);

    ptsl_pkg::state_t                state_reg, state_next;
    logic [ptsl_pkg::CNT_W-1:0]      cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptsl_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        cmd.op     = ptsl_pkg::OP_NONE;
        cmd.idx    = cnt_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ptsl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = ptsl_pkg::OP_LOAD;
                    state_next = ptsl_pkg::ST_DISPATCH;
                end
            end
            ptsl_pkg::ST_DISPATCH:
                state_next = status.present ? ptsl_pkg::ST_VEC : ptsl_pkg::ST_EVAL;
            ptsl_pkg::ST_VEC:
            begin
                cmd.op = ptsl_pkg::OP_VEC;
                if (cnt_reg == ptsl_pkg::CNT_W'(ptsl_pkg::CORDIC_ITERATIONS - 1))
                    state_next = ptsl_pkg::ST_DMUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ptsl_pkg::ST_DMUL:
            begin
                cmd.op     = ptsl_pkg::OP_DMUL;
                state_next = ptsl_pkg::ST_DIST;
            end
            ptsl_pkg::ST_DIST:
            begin
                cmd.op     = ptsl_pkg::OP_DIST;
                state_next = status.out_of_arc ? ptsl_pkg::ST_EVAL : ptsl_pkg::ST_ROT;
            end
            ptsl_pkg::ST_ROT:
            begin
                cmd.op = ptsl_pkg::OP_ROT;
                if (cnt_reg == ptsl_pkg::CNT_W'(ptsl_pkg::CORDIC_ITERATIONS - 1))
                    state_next = ptsl_pkg::ST_LMUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ptsl_pkg::ST_LMUL:
            begin
                cmd.op     = ptsl_pkg::OP_LMUL;
                state_next = ptsl_pkg::ST_LD;
            end
            ptsl_pkg::ST_LD:
            begin
                cmd.op     = ptsl_pkg::OP_LD;
                state_next = ptsl_pkg::ST_ADMUL;
            end
            ptsl_pkg::ST_ADMUL:
            begin
                cmd.op     = ptsl_pkg::OP_ADMUL;
                state_next = ptsl_pkg::ST_VVMUL;
            end
            ptsl_pkg::ST_VVMUL:
            begin
                cmd.op     = ptsl_pkg::OP_VVMUL;
                state_next = ptsl_pkg::ST_DISC;
            end
            ptsl_pkg::ST_DISC:
            begin
                cmd.op     = ptsl_pkg::OP_DISC;
                state_next = status.stop_short ? ptsl_pkg::ST_EVAL : ptsl_pkg::ST_SQRT;
            end
            ptsl_pkg::ST_SQRT:
            begin
                cmd.op = ptsl_pkg::OP_SQRT;
                if (cnt_reg == ptsl_pkg::CNT_W'(ptsl_pkg::SQRT_STEPS - 1))
                    state_next = ptsl_pkg::ST_TPREP;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ptsl_pkg::ST_TPREP:
            begin
                cmd.op     = ptsl_pkg::OP_TPREP;
                state_next = ptsl_pkg::ST_TDIV;
            end
            ptsl_pkg::ST_TDIV:
            begin
                cmd.op = ptsl_pkg::OP_DIV;
                if (cnt_reg == ptsl_pkg::CNT_W'(ptsl_pkg::DIV_W - 1))
                    state_next = ptsl_pkg::ST_TUPD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ptsl_pkg::ST_TUPD:
            begin
                cmd.op     = ptsl_pkg::OP_TUPD;
                state_next = ptsl_pkg::ST_EVAL;
            end
            ptsl_pkg::ST_EVAL:
            begin
                if (!status.last)
                    state_next = ptsl_pkg::ST_IDLE;
                else if (status.need_div)
                    state_next = ptsl_pkg::ST_FMUL1;
                else
                    state_next = ptsl_pkg::ST_OUT;
            end
            ptsl_pkg::ST_FMUL1:
            begin
                cmd.op     = ptsl_pkg::OP_FMUL1;
                state_next = ptsl_pkg::ST_FMUL2;
            end
            ptsl_pkg::ST_FMUL2:
            begin
                cmd.op     = ptsl_pkg::OP_FMUL2;
                state_next = ptsl_pkg::ST_FPREP;
            end
            ptsl_pkg::ST_FPREP:
            begin
                cmd.op     = ptsl_pkg::OP_FPREP;
                state_next = ptsl_pkg::ST_FDIV;
            end
            ptsl_pkg::ST_FDIV:
            begin
                cmd.op = ptsl_pkg::OP_DIV;
                if (cnt_reg == ptsl_pkg::CNT_W'(ptsl_pkg::DIV_W - 1))
                    state_next = ptsl_pkg::ST_OUT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ptsl_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = ptsl_pkg::OP_OUT;
                    state_next = ptsl_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ptsl_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/ptsl_dp.sv =====
module ptsl_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptsl_pkg::dp_cmd_t                   cmd,
    output ptsl_pkg::dp_status_t                status,
    input  logic                         [15:0] speed,
    input  logic signed                  [31:0] veh_x,
    input  logic signed                  [31:0] veh_y,
    input  logic signed                  [15:0] heading,
    input  logic signed                  [31:0] ped_x,
    input  logic signed                  [31:0] ped_y,
    input  logic                                ped_present,
    input  logic                                last,
    input  logic                                cfg_we,
    input  logic [ptsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptsl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                limited,
    output logic                         [15:0] max_speed,
    output logic                         [15:0] min_ttc,
    output logic                                ttc_finite
);

    localparam logic signed [19:0] PI_Q13      = 20'sd25736;
    localparam logic signed [19:0] TWO_PI_Q13  = 20'sd51472;
    localparam logic        [13:0] HALF_PI_Q13 = 14'd12868;
    localparam logic        [16:0] INV_K_Q16   = 17'd39797;
    localparam logic signed [35:0] INV_K_Q30   = 36'sd652032874;
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
    localparam int                 DW          = ptsl_pkg::DIV_W;
    localparam int                 DVW         = ptsl_pkg::DIVISOR_W;

    // configuration
    logic [13:0] half_arc_reg;
    logic [30:0] stop_dist_reg;
    logic [15:0] ttc_thr_reg;
    logic [15:0] max_decel_reg;
    logic [15:0] floor_vel_reg;

    // item
    logic               [15:0] speed_reg;
    logic signed        [15:0] heading_reg;
    logic                      present_reg;
    logic                      last_reg;

    // shared CORDIC and arithmetic
    logic signed [35:0] x_reg, x_next;
    logic signed [35:0] y_reg, y_next;
    logic signed [19:0] z_reg, z_next;
    logic        [51:0] prod_reg, prod_next;
    logic        [34:0] dist_reg;
    logic        [31:0] ld_reg;
    logic        [48:0] two_ad_reg;
    logic        [39:0] sq_val_reg;
    logic        [21:0] sq_rem_reg;
    logic        [19:0] sq_root_reg;
    logic      [DW-1:0] dv_q_reg;
    logic     [DVW-1:0] dv_r_reg;
    logic     [DVW-1:0] dv_d_reg;

    // list state
    logic        [15:0] best_ttc_reg;
    logic        [31:0] best_ld_reg;
    logic               found_reg;

    // output
    logic               out_valid_reg;
    logic               limited_reg;
    logic        [15:0] max_speed_reg;
    logic        [15:0] min_ttc_reg;
    logic               ttc_finite_reg;

    logic signed [32:0] dx, dy;
    logic signed [35:0] sx, sy;
    logic signed [19:0] at;
    logic signed [19:0] rel0, rel1, rel2, rel3, rel;
    logic signed [19:0] arc_s;
    logic        [13:0] arc;
    logic        [34:0] x_pos;
    logic        [30:0] cx_cl;
    logic        [16:0] cos16;
    logic        [15:0] a_eff;
    logic        [34:0] mul_a;
    logic        [16:0] mul_b;
    logic        [39:0] v2;
    logic        [23:0] sq_rem2;
    logic        [21:0] sq_trial;
    logic        [19:0] vq;
    logic        [19:0] ttc_num;
    logic     [DVW:0]   dv_r2;
    logic        [15:0] quot16;
    logic               limit_hit;
    logic               too_close;

    assign dx = 33'(ped_x) - 33'(veh_x);
    assign dy = 33'(ped_y) - 33'(veh_y);

    assign sx = x_reg >>> cmd.idx;
    assign sy = y_reg >>> cmd.idx;
    assign at = ptsl_pkg::atan_q13(cmd.idx);

    // bearing relative to heading, wrapped into [-pi, pi]
    always_comb
    begin
        rel0 = z_reg - 20'(heading_reg);
        rel1 = (rel0 > PI_Q13) ? rel0 - TWO_PI_Q13 : rel0;
        rel2 = (rel1 < -PI_Q13) ? rel1 + TWO_PI_Q13 : rel1;
        rel3 = (rel2 > PI_Q13) ? rel2 - TWO_PI_Q13 : rel2;
        rel  = (rel3 < -PI_Q13) ? rel3 + TWO_PI_Q13 : rel3;
    end

    assign arc   = (half_arc_reg > HALF_PI_Q13) ? HALF_PI_Q13 : half_arc_reg;
    assign arc_s = $signed({6'b0, arc});

    assign x_pos = x_reg[35] ? '0 : x_reg[34:0];

    always_comb
    begin
        if (x_reg[35])
            cx_cl = '0;
        else if (x_reg > ONE_Q30)
            cx_cl = ONE_Q30[30:0];
        else
            cx_cl = x_reg[30:0];
        cos16 = 17'((32'(cx_cl) + 32'd8192) >> 14);
    end

    assign a_eff = (max_decel_reg == '0) ? 16'd1 : max_decel_reg;
    assign v2    = {prod_reg[31:0], 8'b0};

    assign sq_rem2  = {sq_rem_reg, sq_val_reg[39:38]};
    assign sq_trial = {sq_root_reg, 2'b01};

    assign vq      = {speed_reg, 4'b0};
    assign ttc_num = (vq > sq_root_reg) ? vq - sq_root_reg : '0;

    assign dv_r2  = {dv_r_reg, dv_q_reg[DW-1]};
    assign quot16 = (|dv_q_reg[DW-1:16]) ? 16'hFFFF : dv_q_reg[15:0];

    assign limit_hit = found_reg && (best_ttc_reg < ttc_thr_reg);
    assign too_close = best_ld_reg < 32'(stop_dist_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            ptsl_pkg::OP_DMUL:
            begin
                mul_a = x_pos;
                mul_b = INV_K_Q16;
            end
            ptsl_pkg::OP_LMUL:
            begin
                mul_a = dist_reg;
                mul_b = cos16;
            end
            ptsl_pkg::OP_ADMUL:
            begin
                mul_a = 35'(ld_reg);
                mul_b = 17'(a_eff);
            end
            ptsl_pkg::OP_VVMUL:
            begin
                mul_a = 35'(speed_reg);
                mul_b = 17'(speed_reg);
            end
            ptsl_pkg::OP_FMUL1:
            begin
                mul_a = 35'(max_decel_reg);
                mul_b = 17'(ttc_thr_reg);
            end
            ptsl_pkg::OP_FMUL2:
            begin
                mul_a = 35'(prod_reg[31:0]);
                mul_b = 17'(ttc_thr_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = 52'(mul_a) * 52'(mul_b);
    end

    // CORDIC register update
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        case (cmd.op)
            ptsl_pkg::OP_LOAD:
            begin
                if (dx[32])
                begin
                    x_next = -36'(dx);
                    y_next = -36'(dy);
                    z_next = dy[32] ? -PI_Q13 : PI_Q13;
                end
                else
                begin
                    x_next = 36'(dx);
                    y_next = 36'(dy);
                    z_next = '0;
                end
            end
            ptsl_pkg::OP_VEC:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                    z_next = z_reg + at;
                end
                else
                begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                    z_next = z_reg - at;
                end
            end
            ptsl_pkg::OP_DIST:
            begin
                x_next = INV_K_Q30;
                y_next = '0;
                z_next = rel;
            end
            ptsl_pkg::OP_ROT:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                    z_next = z_reg + at;
                end
            end
            default:
            begin
                x_next = x_reg;
                y_next = y_reg;
                z_next = z_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_arc_reg  <= 14'd6434;
            stop_dist_reg <= 31'd196608;
            ttc_thr_reg   <= 16'd768;
            max_decel_reg <= 16'd768;
            floor_vel_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (ptsl_pkg::cfg_idx_t'(cfg_index))
                ptsl_pkg::CFG_HALF_ARC:  half_arc_reg  <= cfg_data[13:0];
                ptsl_pkg::CFG_STOP_DIST: stop_dist_reg <= cfg_data[30:0];
                ptsl_pkg::CFG_TTC_THR:   ttc_thr_reg   <= cfg_data[15:0];
                ptsl_pkg::CFG_MAX_DECEL: max_decel_reg <= cfg_data[15:0];
                ptsl_pkg::CFG_FLOOR_VEL: floor_vel_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        prod_reg <= prod_next;
        case (cmd.op)
            ptsl_pkg::OP_LOAD:
            begin
                speed_reg   <= speed;
                heading_reg <= heading;
                present_reg <= ped_present;
                last_reg    <= last;
            end
            ptsl_pkg::OP_DIST:
                dist_reg <= prod_reg[50:16] + 35'(prod_reg[15]);
            ptsl_pkg::OP_LD:
                ld_reg <= (|prod_reg[51:48]) ? 32'hFFFF_FFFF : prod_reg[47:16];
            ptsl_pkg::OP_VVMUL:
                two_ad_reg <= {prod_reg[47:0], 1'b0};
            ptsl_pkg::OP_DISC:
            begin
                sq_val_reg  <= v2 - two_ad_reg[39:0];
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            ptsl_pkg::OP_SQRT:
            begin
                sq_val_reg <= {sq_val_reg[37:0], 2'b00};
                if (sq_rem2 >= 24'(sq_trial))
                begin
                    sq_rem_reg  <= 22'(sq_rem2 - 24'(sq_trial));
                    sq_root_reg <= {sq_root_reg[18:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg  <= sq_rem2[21:0];
                    sq_root_reg <= {sq_root_reg[18:0], 1'b0};
                end
            end
            ptsl_pkg::OP_TPREP:
            begin
                dv_q_reg <= DW'({ttc_num, 4'b0});
                dv_r_reg <= '0;
                dv_d_reg <= DVW'(a_eff);
            end
            ptsl_pkg::OP_FPREP:
            begin
                dv_q_reg <= DW'({best_ld_reg, 9'b0}) + DW'(prod_reg[47:0]);
                dv_r_reg <= '0;
                dv_d_reg <= {ttc_thr_reg, 9'b0};
            end
            ptsl_pkg::OP_DIV:
            begin
                if (dv_r2 >= {1'b0, dv_d_reg})
                begin
                    dv_r_reg <= DVW'(dv_r2 - {1'b0, dv_d_reg});
                    dv_q_reg <= {dv_q_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    dv_r_reg <= dv_r2[DVW-1:0];
                    dv_q_reg <= {dv_q_reg[DW-2:0], 1'b0};
                end
            end
            ptsl_pkg::OP_OUT:
            begin
                limited_reg    <= limit_hit;
                min_ttc_reg    <= found_reg ? best_ttc_reg : '0;
                ttc_finite_reg <= found_reg;
                if (!limit_hit)
                    max_speed_reg <= 16'hFFFF;
                else if (too_close)
                    max_speed_reg <= '0;
                else
                    max_speed_reg <= (quot16 < floor_vel_reg) ? floor_vel_reg : quot16;
            end
            default: ;
        endcase
    end

    // list state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_ttc_reg  <= '0;
            best_ld_reg   <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == ptsl_pkg::OP_TUPD)
            begin
                if (!found_reg || quot16 < best_ttc_reg)
                begin
                    best_ttc_reg <= quot16;
                    best_ld_reg  <= ld_reg;
                    found_reg    <= 1'b1;
                end
            end
            else if (cmd.op == ptsl_pkg::OP_OUT)
            begin
                best_ttc_reg <= '0;
                best_ld_reg  <= '0;
                found_reg    <= 1'b0;
            end

            if (cmd.op == ptsl_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.present    = present_reg;
        status.last       = last_reg;
        status.out_of_arc = (rel > arc_s) || (rel < -arc_s);
        status.stop_short = two_ad_reg > 49'(v2);
        status.need_div   = limit_hit && !too_close;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign limited    = limited_reg;
    assign max_speed  = max_speed_reg;
    assign min_ttc    = min_ttc_reg;
    assign ttc_finite = ttc_finite_reg;

endmodule

// ===== hw/rtl/pedestrian_ttc_speed_limit.sv =====
// Pedestrian time-to-collision speed limiter.
// in_ch: one request per pedestrian (vehicle pose and speed, one pedestrian
//   position, ped_present, last). A list ends with last = 1; an item with
//   ped_present = 0 is an empty marker that only carries last.
// out_ch: one request per list, issued after its last item: limited,
//   max_speed, min_ttc, ttc_finite.
// cfg: register writes (index 0..4); always ready, write only while idle.
// One item is processed at a time. A pedestrian takes the load step,
//   16 vectoring and 16 rotation steps of the shared CORDIC,
//   20 square root steps, 49 divider steps, plus the multiply steps.
//   Pedestrians outside the arc end after the distance step, those short
//   of stopping after the discriminant; markers skip these steps. The last
//   item adds two multiplies and a 49-step divide when a nonzero limit
//   has to be computed, using the single 35x17 multiplier and bit-serial divider.
// Reset clears the list state, loads the register defaults and empties the
//   output register. A stalled out_ch holds the result in the output
//   register; the next item is still taken and worked on, and only the next
//   result waits until the register is free.
module pedestrian_ttc_speed_limit (
    input  logic              clk,
    input  logic              rst_n,
    ptsl_in_if.sink           in_ch,
    ptsl_out_if.source        out_ch,
    ptsl_cfg_if.sink          cfg
);

    ptsl_pkg::dp_cmd_t    cmd;
    ptsl_pkg::dp_status_t status;
    logic                 in_ready;

    assign in_ch.ready = in_ready;
    assign cfg.ready   = 1'b1;

    ptsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    ptsl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .speed       (in_ch.speed),
        .veh_x       (in_ch.veh_x),
        .veh_y       (in_ch.veh_y),
        .heading     (in_ch.heading),
        .ped_x       (in_ch.ped_x),
        .ped_y       (in_ch.ped_y),
        .ped_present (in_ch.ped_present),
        .last        (in_ch.last),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .limited     (out_ch.limited),
        .max_speed   (out_ch.max_speed),
        .min_ttc     (out_ch.min_ttc),
        .ttc_finite  (out_ch.ttc_finite)
    );

endmodule

// ===== hw/rtl/ptsl_checker.sv =====
`include "pedestrian_ttc_speed_limit_defines.svh"

module ptsl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_present,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_limited,
    input logic [15:0] out_max_speed,
    input logic [15:0] out_min_ttc,
    input logic        out_ttc_finite
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    `PTSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `PTSL_ASSERT_NEXT(a_busy_after_ped, in_acc && in_present, !in_ready)
    `PTSL_ASSERT_NEXT(a_no_result_mid_list, in_acc && !in_last && !out_valid, !out_valid)
    `PTSL_ASSERT_NOW(a_unlimited_speed, out_valid && !out_limited, out_max_speed == 16'hFFFF)
    `PTSL_ASSERT_NOW(a_none_found, out_valid && !out_ttc_finite, !out_limited && out_min_ttc == 16'd0)

endmodule

bind pedestrian_ttc_speed_limit ptsl_checker u_ptsl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_present     (in_ch.ped_present),
    .in_last        (in_ch.last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_limited    (out_ch.limited),
    .out_max_speed  (out_ch.max_speed),
    .out_min_ttc    (out_ch.min_ttc),
    .out_ttc_finite (out_ch.ttc_finite)
);
